@@ rtl/waypoint_sequencer_assert.svh @@
// Assertion macros for the waypoint sequencer. They expect clk and rst_n in scope.
`ifndef WAYPOINT_SEQUENCER_ASSERT_SVH
`define WAYPOINT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define WPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define WPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wps_pkg.sv @@
package wps_pkg;

    localparam int PATH_DEPTH = 256;
    localparam int ADDR_W     = $clog2(PATH_DEPTH);
    localparam int IDX_W      = $clog2(PATH_DEPTH + 1);
    localparam int COORD_W    = 24;
    localparam int TOL_W      = 16;
    localparam int TOL_SQ_W   = 2 * TOL_W;
    localparam int DIST_SQ_W  = 2 * COORD_W + 2;

    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(500);
    localparam logic [TOL_SQ_W-1:0] TOL_SQ_RESET = TOL_SQ_W'(500 * 500);
    localparam logic [IDX_W-1:0]    DEPTH_IDX    = IDX_W'(PATH_DEPTH);

    typedef enum logic [1:0] {
        KIND_POSE = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      first_point;
        logic                      last_point;
    } in_word_t;

    typedef struct packed {
        logic                      waypoint_valid;
        logic                      reached_end;
        logic [IDX_W-1:0]          waypoint_index;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } out_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        point_t            data;
    } mem_wr_t;

endpackage

@@ rtl/wps_path_mem.sv @@
module wps_path_mem (
    input  logic                           clk,
    input  wps_pkg::mem_wr_t               wr,
    input  logic [wps_pkg::ADDR_W-1:0]     rd_addr_a,
    input  logic [wps_pkg::ADDR_W-1:0]     rd_addr_b,
    output wps_pkg::point_t                rd_data_a,
    output wps_pkg::point_t                rd_data_b
);
    import wps_pkg::*;

    point_t mem [PATH_DEPTH];
    point_t rd_a_reg;
    point_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Forward a same-cycle write so the read register never holds stale data.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= (wr.en && (wr.addr == rd_addr_a)) ? wr.data : mem[rd_addr_a];
        rd_b_reg <= (wr.en && (wr.addr == rd_addr_b)) ? wr.data : mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/wps_dist.sv @@
module wps_dist (
    input  wps_pkg::point_t                pose,
    input  wps_pkg::point_t                wp,
    input  logic [wps_pkg::TOL_SQ_W-1:0]   tol_sq,
    output logic                           in_radius
);
    import wps_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    logic [COORD_W-1:0]     mx;
    logic [COORD_W-1:0]     my;
    logic [COORD_W-1:0]     mz;
    logic [2*COORD_W-1:0]   sx;
    logic [2*COORD_W-1:0]   sy;
    logic [2*COORD_W-1:0]   sz;
    logic [DIST_SQ_W-1:0]   d2;

    assign mx = abs_diff(pose.x, wp.x);
    assign my = abs_diff(pose.y, wp.y);
    assign mz = abs_diff(pose.z, wp.z);

    assign sx = mx * mx;
    assign sy = my * my;
    assign sz = mz * mz;

    assign d2 = DIST_SQ_W'(sx) + DIST_SQ_W'(sy) + DIST_SQ_W'(sz);

    // Strict compare: exactly on the radius does not count.
    assign in_radius = d2 < DIST_SQ_W'(tol_sq);

endmodule

@@ rtl/wps_core.sv @@
module wps_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  wps_pkg::in_word_t           word,
    input  logic                        cfg_wr_en,
    input  logic [wps_pkg::TOL_W-1:0]   cfg_wr_data,
    output logic                        has_result,
    output wps_pkg::out_word_t          result
);
    import wps_pkg::*;

    point_t               pose_reg;
    point_t               pose_next;
    logic                 pose_present_reg;
    logic                 pose_present_next;
    logic                 path_present_reg;
    logic                 path_present_next;
    logic [IDX_W-1:0]     len_reg;
    logic [IDX_W-1:0]     len_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [TOL_SQ_W-1:0]  tol_sq_reg;

    point_t               in_pt;
    point_t               wp_cur;
    point_t               wp_nxt;
    point_t               tgt;
    mem_wr_t              mem_wr;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [ADDR_W-1:0]    rd_addr_b;
    logic [IDX_W-1:0]     len_base;
    logic                 in_radius;
    logic                 in_range;
    logic                 advance;
    logic                 out_range;
    logic [IDX_W-1:0]     idx_tick;

    assign in_pt = '{x: word.pos_x, y: word.pos_y, z: word.pos_z};

    // Prefetch current and following waypoint for the index of the next cycle.
    assign rd_addr_a = idx_next[ADDR_W-1:0];
    assign rd_addr_b = rd_addr_a + ADDR_W'(1);

    wps_path_mem u_mem (
        .clk       (clk),
        .wr        (mem_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (wp_cur),
        .rd_data_b (wp_nxt)
    );

    wps_dist u_dist (
        .pose      (pose_reg),
        .wp        (wp_cur),
        .tol_sq    (tol_sq_reg),
        .in_radius (in_radius)
    );

    assign in_range  = idx_reg < len_reg;
    assign advance   = in_range && in_radius;
    assign idx_tick  = idx_reg + IDX_W'(advance);
    assign out_range = idx_tick < len_reg;
    assign tgt       = advance ? wp_nxt : wp_cur;
    assign len_base  = word.first_point ? '0 : len_reg;

    assign has_result = (word.kind == KIND_TICK) && pose_present_reg
                        && path_present_reg && (len_reg != '0);

    always_comb
    begin
        result.waypoint_valid = out_range;
        result.reached_end    = !out_range;
        result.waypoint_index = idx_tick;
        result.target_x       = out_range ? tgt.x : '0;
        result.target_y       = out_range ? tgt.y : '0;
        result.target_z       = out_range ? tgt.z : '0;
    end

    always_comb
    begin
        pose_next         = pose_reg;
        pose_present_next = pose_present_reg;
        path_present_next = path_present_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        mem_wr.en         = 1'b0;
        mem_wr.addr       = len_base[ADDR_W-1:0];
        mem_wr.data       = in_pt;
        if (fire)
        begin
            unique case (word.kind)
                KIND_POSE:
                begin
                    pose_next         = in_pt;
                    pose_present_next = 1'b1;
                end
                KIND_LOAD:
                begin
                    if (word.first_point)
                    begin
                        idx_next          = '0;
                        path_present_next = 1'b0;
                    end
                    len_next = len_base;
                    // Drop points once the store is full.
                    if (len_base < DEPTH_IDX)
                    begin
                        mem_wr.en = 1'b1;
                        len_next  = len_base + IDX_W'(1);
                    end
                    if (word.last_point)
                    begin
                        path_present_next = 1'b1;
                        idx_next          = '0;
                    end
                end
                KIND_TICK:
                begin
                    if (has_result)
                    begin
                        idx_next = idx_tick;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg         <= '0;
            pose_present_reg <= 1'b0;
            path_present_reg <= 1'b0;
            len_reg          <= '0;
            idx_reg          <= '0;
            tol_sq_reg       <= TOL_SQ_RESET;
        end
        else
        begin
            pose_reg         <= pose_next;
            pose_present_reg <= pose_present_next;
            path_present_reg <= path_present_next;
            len_reg          <= len_next;
            idx_reg          <= idx_next;
            if (cfg_wr_en)
            begin
                tol_sq_reg <= TOL_SQ_W'(cfg_wr_data) * TOL_SQ_W'(cfg_wr_data);
            end
        end
    end

endmodule

@@ rtl/waypoint_sequencer.sv @@
// Waypoint sequencer: follows a stored 3-D path with an acceptance radius.
// Input channel (in_valid / in_stall / in_word) carries three kinds of word:
// pose update, path point load, and tick. Only a tick with a stored pose and
// a complete path yields a result word on the output channel (out_valid /
// out_stall / out_word); every other word is absorbed silently.
// Config: cfg_wr_en with cfg_wr_data sets the acceptance radius in mm;
// write it only while no word is in flight. Reset value is 500 mm.
// A word accepted into the input register is processed there when it fires,
// and a tick's result word is loaded into the output register, raising out_valid.
// Throughput is one word per cycle unless a result backs up at a stalled output; the
// path memory does at most one write and two registered reads (current and
// following waypoint) every cycle.
// Reset clears pose, path length, index and both present flags; the path
// memory keeps its contents, which feed no result before they are rewritten.
// When the receiver stalls, the result is held in the output register, and
// the input register keeps taking words until a tick that yields a result
// backs up behind it; in_stall then rises until the output register frees.
`include "waypoint_sequencer_assert.svh"

module waypoint_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  wps_pkg::in_word_t           in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output wps_pkg::out_word_t          out_word,
    input  logic                        cfg_wr_en,
    input  logic [wps_pkg::TOL_W-1:0]   cfg_wr_data
);
    import wps_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_word_t   s1_word_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_word_reg;
    logic       s1_fire;
    logic       in_take;
    logic       core_has_result;
    out_word_t  core_result;
    logic       res_flags_ok;
    logic       res_idx_ok;
    logic       res_load;

    wps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .word        (s1_word_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .has_result  (core_has_result),
        .result      (core_result)
    );

    // Advance the held word unless its result has nowhere to go.
    assign s1_fire  = s1_valid_reg && (!core_has_result || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_fire);
    assign out_valid_next = (s1_fire && core_has_result) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_fire && core_has_result)
        begin
            out_word_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign res_flags_ok = out_word_reg.waypoint_valid != out_word_reg.reached_end;
    assign res_idx_ok   = !out_word_reg.waypoint_valid
                          || (out_word_reg.waypoint_index < DEPTH_IDX);
    assign res_load     = s1_fire && core_has_result;

    `WPS_ASSERT_IMPLY(a_end_excl, out_valid_reg, res_flags_ok, "waypoint and end flags clash")
    `WPS_ASSERT_IMPLY(a_idx_bound, out_valid_reg, res_idx_ok, "target index beyond store")
    `WPS_ASSERT_IMPLY(a_stall_full, in_stall, s1_valid_reg, "stall with empty input register")
    `WPS_ASSERT_NEXT(a_result_lands, res_load, out_valid_reg, "result word lost")

endmodule
